// ===== rtl/core/sha1bc_pkg.sv =====
// Shared types, constants and round functions for the SHA-1 block compressor.
package sha1bc_pkg;

    localparam int WordW    = 32;
    localparam int NumChain = 5;
    localparam int NumMsg   = 16;

    typedef logic [WordW-1:0] t_word;
    typedef logic [2:0]       t_chain_idx;
    typedef logic [3:0]       t_msg_idx;
    typedef logic [6:0]       t_round;
    typedef t_word [NumChain-1:0] t_chain_vec;

    // Input function codes
    localparam logic FUNC_CHAIN = 1'b0;
    localparam logic FUNC_MSG   = 1'b1;

    localparam t_chain_idx LastChainIdx = 3'd4;
    localparam t_msg_idx   LastMsgIdx   = 4'd15;
    localparam t_round     LastRound    = 7'd79;
    localparam t_round     ExpandStart  = 7'd16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FEED,
        ST_SEND
    } t_state;

    // Control from the sequencer to the message schedule
    typedef struct packed {
        logic load;
        logic step;
        logic expand;
    } t_sched_ctl;

    // Control from the sequencer to the round unit
    typedef struct packed {
        logic   init;
        logic   step;
        t_round round;
    } t_round_ctl;

    // Round constant for each group of twenty rounds
    function automatic t_word round_k(input t_round rnd);
        t_word k;
        if (rnd < 7'd20) begin
            k = 32'h5A827999;
        end else if (rnd < 7'd40) begin
            k = 32'h6ED9EBA1;
        end else if (rnd < 7'd60) begin
            k = 32'h8F1BBCDC;
        end else begin
            k = 32'hCA62C1D6;
        end
        return k;
    endfunction

    // Choose, parity, majority, parity
    function automatic t_word round_f(input t_round rnd, input t_word b,
                                      input t_word c, input t_word d);
        t_word f;
        if (rnd < 7'd20) begin
            f = (b & c) | (~b & d);
        end else if (rnd < 7'd40) begin
            f = b ^ c ^ d;
        end else if (rnd < 7'd60) begin
            f = (b & c) | (b & d) | (c & d);
        end else begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

endpackage

// ===== rtl/core/sha1bc_if.sv =====
// Handshake channels: input words and digest words.
interface sha1bc_in_if;
    import sha1bc_pkg::*;
    logic  valid;
    logic  ready;
    logic  func;
    t_word data_word;

    modport source(output valid, output func, output data_word, input ready);
    modport sink(input valid, input func, input data_word, output ready);
endinterface

interface sha1bc_out_if;
    import sha1bc_pkg::*;
    logic       valid;
    logic       ready;
    t_word      digest_word;
    t_chain_idx word_index;
    logic       last_word;

    modport source(output valid, output digest_word, output word_index,
                   output last_word, input ready);
    modport sink(input valid, input digest_word, input word_index,
                 input last_word, output ready);
endinterface

// ===== rtl/core/sha1bc_sched.sv =====
// Message schedule: sixteen-word shift window with in-place expansion.
module sha1bc_sched (
    input  logic                   i_clk,
    input  sha1bc_pkg::t_sched_ctl i_ctl,
    input  sha1bc_pkg::t_word      i_load_word,
    output sha1bc_pkg::t_word      o_wt
);
    import sha1bc_pkg::*;

    // r_win[0] holds W[t-16], r_win[15] holds W[t-1]
    t_word r_win [NumMsg];
    t_word w_mix;
    t_word n_new;

    // W[t] = rotl1(W[t-3] ^ W[t-8] ^ W[t-14] ^ W[t-16]); early rounds recirculate
    always_comb begin
        w_mix = r_win[13] ^ r_win[8] ^ r_win[2] ^ r_win[0];
        n_new = i_ctl.expand ? {w_mix[WordW-2:0], w_mix[WordW-1]} : r_win[0];
    end

    assign o_wt = n_new;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load || i_ctl.step) begin
            for (int i = 0; i < NumMsg - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[NumMsg-1] <= i_ctl.load ? i_load_word : n_new;
        end
    end

endmodule

// ===== rtl/core/sha1bc_round.sv =====
// Round unit: working variables A..E and one SHA-1 round per step.
module sha1bc_round (
    input  logic                   i_clk,
    input  sha1bc_pkg::t_round_ctl i_ctl,
    input  sha1bc_pkg::t_chain_vec i_chain,
    input  sha1bc_pkg::t_word      i_wt,
    output sha1bc_pkg::t_chain_vec o_work
);
    import sha1bc_pkg::*;

    t_chain_vec r_work;
    t_word      w_a, w_b, w_c, w_d, w_e;
    t_word      n_t;

    always_comb begin
        w_a = r_work[0];
        w_b = r_work[1];
        w_c = r_work[2];
        w_d = r_work[3];
        w_e = r_work[4];
        n_t = {w_a[WordW-6:0], w_a[WordW-1:WordW-5]}
            + round_f(i_ctl.round, w_b, w_c, w_d)
            + w_e + round_k(i_ctl.round) + i_wt;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.init) begin
            r_work <= i_chain;
        end else if (i_ctl.step) begin
            r_work[4] <= w_d;
            r_work[3] <= w_c;
            r_work[2] <= {w_b[1:0], w_b[WordW-1:2]};
            r_work[1] <= w_a;
            r_work[0] <= n_t;
        end
    end

    assign o_work = r_work;

endmodule

// ===== rtl/core/sha1_block_compress.sv =====
// SHA-1 block compressor: load five chaining words (func 0) and sixteen message
// words (func 1); the sixteenth message word starts 80 rounds at one round per
// clock through a single round adder, after which the five updated chaining words
// come out in order A..E, the last marked, each through a feed-forward state and
// then a send state that holds until the sink takes it. Input ready is low from
// the sixteenth message beat until word E is taken. The chaining value stays
// inside and is updated in place, so later blocks need only message words; it
// must be loaded once before the first block.
module sha1_block_compress (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sha1bc_in_if.sink    i_in,
    sha1bc_out_if.source o_out
);
    import sha1bc_pkg::*;

    t_state     r_state, n_state;
    t_chain_idx r_chain_cnt, n_chain_cnt;
    t_msg_idx   r_msg_cnt, n_msg_cnt;
    t_round     r_round, n_round;
    t_chain_idx r_out_idx, n_out_idx;
    t_chain_vec r_chain;
    t_word      r_out_data;
    t_word      n_sum;

    logic       w_in_acc;
    logic       w_out_acc;
    logic       w_feed;
    t_sched_ctl w_sched_ctl;
    t_round_ctl w_round_ctl;
    t_word      w_wt;
    t_chain_vec w_work;

    // Input is taken only while idle
    assign i_in.ready = (r_state == ST_IDLE);

    assign w_in_acc  = i_in.valid && i_in.ready;
    assign w_out_acc = o_out.valid && o_out.ready;

    sha1bc_sched u_sched (
        .i_clk       (i_clk),
        .i_ctl       (w_sched_ctl),
        .i_load_word (i_in.data_word),
        .o_wt        (w_wt)
    );

    sha1bc_round u_round (
        .i_clk   (i_clk),
        .i_ctl   (w_round_ctl),
        .i_chain (r_chain),
        .i_wt    (w_wt),
        .o_work  (w_work)
    );

    // Sequencer: next state, counters and unit control
    always_comb begin
        n_state     = r_state;
        n_chain_cnt = r_chain_cnt;
        n_msg_cnt   = r_msg_cnt;
        n_round     = r_round;
        n_out_idx   = r_out_idx;
        w_feed      = 1'b0;
        w_sched_ctl = '0;
        w_round_ctl = '0;
        w_round_ctl.round = r_round;

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_in.func == FUNC_CHAIN) begin
                        n_chain_cnt = (r_chain_cnt == LastChainIdx) ? '0 : r_chain_cnt + 3'd1;
                    end else begin
                        w_sched_ctl.load = 1'b1;
                        n_msg_cnt = r_msg_cnt + 4'd1;
                        if (r_msg_cnt == LastMsgIdx) begin
                            w_round_ctl.init = 1'b1;
                            n_state = ST_ROUND;
                        end
                    end
                end
            end
            ST_ROUND: begin
                w_sched_ctl.step   = 1'b1;
                w_sched_ctl.expand = (r_round >= ExpandStart);
                w_round_ctl.step   = 1'b1;
                if (r_round == LastRound) begin
                    n_round = '0;
                    n_state = ST_FEED;
                end else begin
                    n_round = r_round + 7'd1;
                end
            end
            ST_FEED: begin
                w_feed  = 1'b1;
                n_state = ST_SEND;
            end
            ST_SEND: begin
                if (w_out_acc) begin
                    if (r_out_idx == LastChainIdx) begin
                        n_out_idx = '0;
                        n_state   = ST_IDLE;
                    end else begin
                        n_out_idx = r_out_idx + 3'd1;
                        n_state   = ST_FEED;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Feed-forward add for the current output word
    assign n_sum = r_chain[r_out_idx] + w_work[r_out_idx];

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_chain_cnt <= '0;
            r_msg_cnt   <= '0;
            r_round     <= '0;
            r_out_idx   <= '0;
        end else begin
            r_state     <= n_state;
            r_chain_cnt <= n_chain_cnt;
            r_msg_cnt   <= n_msg_cnt;
            r_round     <= n_round;
            r_out_idx   <= n_out_idx;
        end
    end

    // Chaining value and output word
    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_in.func == FUNC_CHAIN) begin
            r_chain[r_chain_cnt] <= i_in.data_word;
        end
        if (w_feed) begin
            r_chain[r_out_idx] <= n_sum;
            r_out_data         <= n_sum;
        end
    end

    assign o_out.valid       = (r_state == ST_SEND);
    assign o_out.digest_word = r_out_data;
    assign o_out.word_index  = r_out_idx;
    assign o_out.last_word   = (r_out_idx == LastChainIdx);

`ifndef SYNTHESIS
    // Round counter is parked at zero outside the round loop
    a_round_parked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_ROUND |-> r_round == '0)
        else $error("round counter not zero outside rounds");

    // Sixteenth message beat starts the rounds
    a_start_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_in.func == FUNC_MSG && r_msg_cnt == LastMsgIdx
        |=> r_state == ST_ROUND && r_round == '0)
        else $error("rounds did not start after last message word");

    // Last round hands over to the output phase at word A
    a_round_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_ROUND && r_round == LastRound
        |=> r_state == ST_FEED && r_out_idx == '0)
        else $error("output phase did not start at word A");

    // Taking the last word returns the block to accepting input
    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc && o_out.last_word |=> i_in.ready && r_msg_cnt == '0)
        else $error("block not ready after last digest word");

    // Output and chaining-load indices stay within A..E
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_idx <= LastChainIdx && r_chain_cnt <= LastChainIdx)
        else $error("chaining index out of range");
`endif

endmodule
